>>> src/arp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP resolver package
// Table sizes, codes, and the types shared by the front, back and top level.
// ----------------------------------------------------------------------------
package arp_pkg;

	// table sizes
	localparam int CACHE_N = 16;
	localparam int REQ_N   = 8;
	localparam int HELD_N  = 16;
	localparam int CIW     = (CACHE_N > 1) ? $clog2(CACHE_N) : 1;
	localparam int RIW     = (REQ_N > 1) ? $clog2(REQ_N) : 1;
	localparam int HIW     = (HELD_N > 1) ? $clog2(HELD_N) : 1;
	localparam int HCW     = $clog2(HELD_N + 1);

	// front to back queue, depth a power of two
	localparam int QD  = 2;
	localparam int QIW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	// config port
	localparam int CFG_IW = 8;
	localparam int CFG_DW = 48;
	localparam logic [CFG_IW-1:0] CFG_OWN_MAC   = 8'd0;
	localparam logic [CFG_IW-1:0] CFG_OWN_IP    = 8'd1;
	localparam logic [CFG_IW-1:0] CFG_CACHE_TTL = 8'd2;
	localparam logic [CFG_IW-1:0] CFG_ARP_RETRY = 8'd3;
	localparam logic [31:0] TTL_RST   = 32'd30000;
	localparam logic [31:0] RETRY_RST = 32'd5000;

	// input codes
	localparam logic [1:0] KIND_SEND   = 2'd0;
	localparam logic [1:0] KIND_FRAME  = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;
	localparam logic [1:0] FTYPE_IPV4  = 2'd0;
	localparam logic [1:0] FTYPE_ARP   = 2'd1;
	localparam logic [1:0] FTYPE_OTHER = 2'd2;
	localparam logic [1:0] FTYPE_RSVD  = 2'd3;

	// queued operation codes
	localparam logic [1:0] OP_SEND  = 2'd0;
	localparam logic [1:0] OP_ARP   = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_DELIV = 2'd3;

	// result actions
	localparam logic [2:0] ACT_IPV4  = 3'd0;
	localparam logic [2:0] ACT_REQ   = 3'd1;
	localparam logic [2:0] ACT_REPLY = 3'd2;
	localparam logic [2:0] ACT_DELIV = 3'd3;
	localparam logic [2:0] ACT_DROP  = 3'd4;

	localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

	// classified word passed from front to back
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] ip;      // next hop for sends, sender IP for ARP
		logic [15:0] tag;
		logic        is_req;
		logic [47:0] smac;
		logic [31:0] tip;
		logic [15:0] dt;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic [47:0] own_mac;
		logic [31:0] own_ip;
		logic [31:0] ttl;
		logic [31:0] retry;
	} cfg_t;

endpackage
`default_nettype wire

>>> src/arp_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP resolver channels
// Input item, result and config write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface arp_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] hop_addr;
	logic [15:0] payload_tag;
	logic [47:0] frame_dst_mac;
	logic [1:0]  frame_type;
	logic        parse_ok;
	logic        arp_is_request;
	logic [47:0] arp_sender_mac;
	logic [31:0] arp_sender_ip;
	logic [31:0] arp_target_ip;
	logic [15:0] tick_ms;
	modport source (output valid, kind, hop_addr, payload_tag, frame_dst_mac, frame_type,
		parse_ok, arp_is_request, arp_sender_mac, arp_sender_ip, arp_target_ip, tick_ms,
		input ready);
	modport sink (input valid, kind, hop_addr, payload_tag, frame_dst_mac, frame_type,
		parse_ok, arp_is_request, arp_sender_mac, arp_sender_ip, arp_target_ip, tick_ms,
		output ready);
endinterface

interface arp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [47:0] dst_mac;
	logic [15:0] out_tag;
	logic [31:0] target_ip;
	logic [47:0] target_mac;
	logic        last;
	modport source (output valid, action, dst_mac, out_tag, target_ip, target_mac, last,
		input ready);
	modport sink (input valid, action, dst_mac, out_tag, target_ip, target_mac, last,
		output ready);
endinterface

interface arp_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/arp_fe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP resolver front end
// Accepts input words, filters and classifies them, queues them for the back.
// ----------------------------------------------------------------------------
module arp_fe (
	input  wire logic          clk,
	input  wire logic          arst_n,
	arp_item_if.sink           item,
	input  wire arp_pkg::cfg_t cfg,
	input  wire logic          pop,
	output arp_pkg::qhead_t    head
);

	arp_pkg::item_t        q_mem [arp_pkg::QD];
	logic [arp_pkg::QIW-1:0] wr_q, rd_q;
	logic [arp_pkg::QCW-1:0] cnt_q;
	arp_pkg::item_t        cls;
	logic                  keep;
	logic                  push;

	// classify: frames not for us, unparsed or of another type, and reserved kinds are swallowed
	always_comb begin
		cls.ip     = item.hop_addr;
		cls.tag    = item.payload_tag;
		cls.is_req = item.arp_is_request;
		cls.smac   = item.arp_sender_mac;
		cls.tip    = item.arp_target_ip;
		cls.dt     = item.tick_ms;
		cls.op     = arp_pkg::OP_SEND;
		keep       = 1'b0;
		case (item.kind)
			arp_pkg::KIND_SEND: begin
				keep = 1'b1;
			end
			arp_pkg::KIND_FRAME: begin
				if ((item.frame_dst_mac == cfg.own_mac ||
				     item.frame_dst_mac == arp_pkg::BCAST_MAC) && item.parse_ok) begin
					if (item.frame_type == arp_pkg::FTYPE_IPV4) begin
						cls.op = arp_pkg::OP_DELIV;
						keep   = 1'b1;
					end else if (item.frame_type == arp_pkg::FTYPE_ARP) begin
						cls.op = arp_pkg::OP_ARP;
						cls.ip = item.arp_sender_ip;
						keep   = 1'b1;
					end
				end
			end
			arp_pkg::KIND_TICK: begin
				cls.op = arp_pkg::OP_TICK;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign item.ready = (cnt_q != arp_pkg::QCW'(arp_pkg::QD));
	assign push       = item.valid && item.ready && keep;

	// two-word queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				q_mem[wr_q] <= cls;
				wr_q        <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = q_mem[rd_q];

endmodule
`default_nettype wire

>>> src/arp_be.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP resolver back end
// Sequencer over the cache, request and held tables; drives the result word.
// ----------------------------------------------------------------------------
module arp_be (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire arp_pkg::cfg_t   cfg,
	input  wire arp_pkg::qhead_t head,
	output logic                 pop,
	arp_result_if.source         result
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SEND  = 4'd1;
	localparam logic [3:0] S_MISS  = 4'd2;
	localparam logic [3:0] S_RSCAN = 4'd3;
	localparam logic [3:0] S_DROP  = 4'd4;
	localparam logic [3:0] S_REQ   = 4'd5;
	localparam logic [3:0] S_HIT   = 4'd6;
	localparam logic [3:0] S_DELIV = 4'd7;
	localparam logic [3:0] S_LEARN = 4'd8;
	localparam logic [3:0] S_CSCAN = 4'd9;
	localparam logic [3:0] S_PEND  = 4'd10;
	localparam logic [3:0] S_FLUSH = 4'd11;
	localparam logic [3:0] S_REPLY = 4'd12;

	localparam int CN = arp_pkg::CACHE_N;
	localparam int RN = arp_pkg::REQ_N;
	localparam int HN = arp_pkg::HELD_N;

	logic [3:0]  st_q;
	logic [31:0] now_q;
	arp_pkg::item_t it_q;

	// tables
	logic        c_val_q [CN];
	logic [31:0] c_ip_q [CN];
	logic [47:0] c_mac_q [CN];
	logic [31:0] c_stamp_q [CN];
	logic        r_val_q [RN];
	logic [31:0] r_ip_q [RN];
	logic [31:0] r_time_q [RN];
	logic [arp_pkg::HCW-1:0] h_cnt_q;
	logic [31:0] h_ip_q [HN];
	logic [15:0] h_tag_q [HN];

	// sequencer scratch
	logic [arp_pkg::CIW-1:0] c_scan_q, cslot_q;
	logic [arp_pkg::RIW-1:0] r_scan_q, rslot_q;
	logic [31:0] best_q;
	logic        drop_q, reqe_q, rep_q;
	logic [HN-1:0] hm_q;
	logic [arp_pkg::HCW-1:0] hi_q, keep_q;
	logic [47:0] hit_mac_q;

	// result register
	logic        o_valid_q;
	logic [2:0]  o_act_q;
	logic [47:0] o_dst_q, o_tmac_q;
	logic [15:0] o_tag_q;
	logic [31:0] o_tip_q;
	logic        o_last_q;

	// match logic
	logic                    c_any, c_free_any, r_any, r_free_any;
	logic [arp_pkg::CIW-1:0] c_first, c_free;
	logic [arp_pkg::RIW-1:0] r_first, r_free;
	logic [HN-1:0]           hm;
	logic                    more;
	logic [arp_pkg::HIW-1:0] hidx, kidx;
	logic [31:0]             c_age, r_age, cs_age, rs_age;
	logic                    held_full, reqe_now;
	logic [arp_pkg::CIW-1:0] cslot_fin;
	logic                    emit_ok;

	// emit request
	logic        em;
	logic [2:0]  em_act;
	logic [47:0] em_dst, em_tmac;
	logic [15:0] em_tag;
	logic [31:0] em_tip;
	logic        em_last;

	// cache and request lookups on the current address
	always_comb begin
		c_any      = 1'b0;
		c_first    = '0;
		c_free_any = 1'b0;
		c_free     = '0;
		for (int j = CN - 1; j >= 0; j--) begin
			if (c_val_q[j] && c_ip_q[j] == it_q.ip) begin
				c_any   = 1'b1;
				c_first = arp_pkg::CIW'(j);
			end
			if (!c_val_q[j]) begin
				c_free_any = 1'b1;
				c_free     = arp_pkg::CIW'(j);
			end
		end
		r_any      = 1'b0;
		r_first    = '0;
		r_free_any = 1'b0;
		r_free     = '0;
		for (int j = RN - 1; j >= 0; j--) begin
			if (r_val_q[j] && r_ip_q[j] == it_q.ip) begin
				r_any   = 1'b1;
				r_first = arp_pkg::RIW'(j);
			end
			if (!r_val_q[j]) begin
				r_free_any = 1'b1;
				r_free     = arp_pkg::RIW'(j);
			end
		end
	end

	// held-entry matches and lookahead for the last flag
	always_comb begin
		more = 1'b0;
		for (int j = 0; j < HN; j++) begin
			hm[j] = (arp_pkg::HCW'(j) < h_cnt_q) && (h_ip_q[j] == it_q.ip);
			if (hm_q[j] && (arp_pkg::HCW'(j) > hi_q)) begin
				more = 1'b1;
			end
		end
	end

	assign hidx      = hi_q[arp_pkg::HIW-1:0];
	assign kidx      = keep_q[arp_pkg::HIW-1:0];
	assign c_age     = now_q - c_stamp_q[c_first];
	assign r_age     = now_q - r_time_q[r_first];
	assign cs_age    = now_q - c_stamp_q[c_scan_q];
	assign rs_age    = now_q - r_time_q[r_scan_q];
	assign held_full = (h_cnt_q == arp_pkg::HCW'(HN));
	assign reqe_now  = r_any ? (r_age > cfg.retry) : 1'b1;
	assign cslot_fin = (c_scan_q == '0 || cs_age > best_q) ? c_scan_q : cslot_q;
	assign emit_ok   = !o_valid_q || result.ready;
	assign pop       = (st_q == S_IDLE) && head.valid;

	// result selection per state
	always_comb begin
		em      = 1'b0;
		em_act  = arp_pkg::ACT_IPV4;
		em_dst  = '0;
		em_tag  = '0;
		em_tip  = '0;
		em_tmac = '0;
		em_last = 1'b1;
		case (st_q)
			S_HIT: begin
				em     = emit_ok;
				em_dst = hit_mac_q;
				em_tag = it_q.tag;
			end
			S_DELIV: begin
				em     = emit_ok;
				em_act = arp_pkg::ACT_DELIV;
				em_tag = it_q.tag;
			end
			S_DROP: begin
				em      = emit_ok;
				em_act  = arp_pkg::ACT_DROP;
				em_tag  = it_q.tag;
				em_last = !reqe_q;
			end
			S_REQ: begin
				em     = emit_ok;
				em_act = arp_pkg::ACT_REQ;
				em_dst = arp_pkg::BCAST_MAC;
				em_tip = it_q.ip;
			end
			S_FLUSH: begin
				em      = emit_ok && (hi_q != h_cnt_q) && hm_q[hidx];
				em_dst  = it_q.smac;
				em_tag  = h_tag_q[hidx];
				em_last = !more && !rep_q;
			end
			S_REPLY: begin
				em      = emit_ok;
				em_act  = arp_pkg::ACT_REPLY;
				em_dst  = it_q.smac;
				em_tip  = it_q.ip;
				em_tmac = it_q.smac;
			end
			default: begin
				em = 1'b0;
			end
		endcase
	end

	// sequencer and tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			now_q     <= '0;
			h_cnt_q   <= '0;
			o_valid_q <= 1'b0;
			for (int j = 0; j < CN; j++) c_val_q[j] <= 1'b0;
			for (int j = 0; j < RN; j++) r_val_q[j] <= 1'b0;
		end else begin
			if (em) begin
				o_valid_q <= 1'b1;
				o_act_q   <= em_act;
				o_dst_q   <= em_dst;
				o_tag_q   <= em_tag;
				o_tip_q   <= em_tip;
				o_tmac_q  <= em_tmac;
				o_last_q  <= em_last;
			end else if (result.ready) begin
				o_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (head.valid) begin
						it_q <= head.item;
						case (head.item.op)
							arp_pkg::OP_TICK:  now_q <= now_q + {16'd0, head.item.dt};
							arp_pkg::OP_SEND:  st_q <= S_SEND;
							arp_pkg::OP_ARP:   st_q <= S_LEARN;
							arp_pkg::OP_DELIV: st_q <= S_DELIV;
							default:           st_q <= S_IDLE;
						endcase
					end
				end
				S_SEND: begin
					// lookup; an expired entry is erased and counts as a miss
					if (c_any && !(c_age > cfg.ttl)) begin
						hit_mac_q <= c_mac_q[c_first];
						st_q      <= S_HIT;
					end else begin
						if (c_any) c_val_q[c_first] <= 1'b0;
						st_q <= S_MISS;
					end
				end
				S_MISS: begin
					drop_q <= held_full;
					if (!held_full) begin
						h_ip_q[h_cnt_q[arp_pkg::HIW-1:0]]  <= it_q.ip;
						h_tag_q[h_cnt_q[arp_pkg::HIW-1:0]] <= it_q.tag;
						h_cnt_q <= h_cnt_q + 1'b1;
					end
					reqe_q <= reqe_now;
					if (r_any || r_free_any) begin
						rslot_q <= r_any ? r_first : r_free;
						st_q    <= held_full ? S_DROP : (reqe_now ? S_REQ : S_IDLE);
					end else begin
						r_scan_q <= '0;
						st_q     <= S_RSCAN;
					end
				end
				S_RSCAN: begin
					// oldest request entry, lowest index on ties
					if (r_scan_q == '0 || rs_age > best_q) begin
						best_q  <= rs_age;
						rslot_q <= r_scan_q;
					end
					if (r_scan_q == arp_pkg::RIW'(RN - 1)) begin
						st_q <= drop_q ? S_DROP : S_REQ;
					end else begin
						r_scan_q <= r_scan_q + 1'b1;
					end
				end
				S_DROP: begin
					if (emit_ok) st_q <= reqe_q ? S_REQ : S_IDLE;
				end
				S_REQ: begin
					if (emit_ok) begin
						r_val_q[rslot_q]  <= 1'b1;
						r_ip_q[rslot_q]   <= it_q.ip;
						r_time_q[rslot_q] <= now_q;
						st_q <= S_IDLE;
					end
				end
				S_HIT, S_DELIV, S_REPLY: begin
					if (emit_ok) st_q <= S_IDLE;
				end
				S_LEARN: begin
					if (c_any || c_free_any) begin
						c_val_q[c_any ? c_first : c_free]   <= 1'b1;
						c_ip_q[c_any ? c_first : c_free]    <= it_q.ip;
						c_mac_q[c_any ? c_first : c_free]   <= it_q.smac;
						c_stamp_q[c_any ? c_first : c_free] <= now_q;
						st_q <= S_PEND;
					end else begin
						c_scan_q <= '0;
						st_q     <= S_CSCAN;
					end
				end
				S_CSCAN: begin
					// oldest cache entry, lowest index on ties
					if (c_scan_q == '0 || cs_age > best_q) begin
						best_q  <= cs_age;
						cslot_q <= c_scan_q;
					end
					if (c_scan_q == arp_pkg::CIW'(CN - 1)) begin
						c_val_q[cslot_fin]   <= 1'b1;
						c_ip_q[cslot_fin]    <= it_q.ip;
						c_mac_q[cslot_fin]   <= it_q.smac;
						c_stamp_q[cslot_fin] <= now_q;
						st_q <= S_PEND;
					end else begin
						c_scan_q <= c_scan_q + 1'b1;
					end
				end
				S_PEND: begin
					rep_q <= it_q.is_req && (it_q.tip == cfg.own_ip);
					if (r_any) begin
						r_val_q[r_first] <= 1'b0;
						hm_q   <= hm;
						hi_q   <= '0;
						keep_q <= '0;
						st_q   <= S_FLUSH;
					end else begin
						st_q <= (it_q.is_req && (it_q.tip == cfg.own_ip)) ? S_REPLY : S_IDLE;
					end
				end
				S_FLUSH: begin
					// release matches in order, repack the rest downward
					if (hi_q == h_cnt_q) begin
						h_cnt_q <= keep_q;
						st_q    <= rep_q ? S_REPLY : S_IDLE;
					end else if (hm_q[hidx]) begin
						if (emit_ok) hi_q <= hi_q + 1'b1;
					end else begin
						h_ip_q[kidx]  <= h_ip_q[hidx];
						h_tag_q[kidx] <= h_tag_q[hidx];
						keep_q <= keep_q + 1'b1;
						hi_q   <= hi_q + 1'b1;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid      = o_valid_q;
	assign result.action     = o_act_q;
	assign result.dst_mac    = o_dst_q;
	assign result.out_tag    = o_tag_q;
	assign result.target_ip  = o_tip_q;
	assign result.target_mac = o_tmac_q;
	assign result.last       = o_last_q;

endmodule
`default_nettype wire

>>> src/arp_resolver_with_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARP resolver with cache
// IPv4 to MAC resolution with aging cache, request pacing and held sends.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      carries
//  item     in   valid/ready    send, received frame or tick word
//  result   out  valid/ready    action word, last marks final of an item
//  cfg      in   valid/ready    register index and write data, always ready
//
//  In the back end a tick only advances the clock, a delivery or hit emits
//  one word, and a send miss holds or drops the send and may emit a request
//  after an oldest-entry scan when the request table is full (one entry per
//  cycle). A received ARP learns the sender, scanning a full cache for its
//  oldest entry, releases held sends, may reply, and waits on result stalls.
//  Reset clears all valid bits, the held count and the clock at once.
//  The result register and a two-word queue let either side stall alone.
// ----------------------------------------------------------------------------
module arp_resolver_with_cache (
	input  wire logic clk,
	input  wire logic arst_n,
	arp_item_if.sink     item,
	arp_result_if.source result,
	arp_cfg_if.sink      cfg
);

	arp_pkg::cfg_t   cfg_q;
	arp_pkg::qhead_t head;
	logic            pop;

	// config registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_mac <= '0;
			cfg_q.own_ip  <= '0;
			cfg_q.ttl     <= arp_pkg::TTL_RST;
			cfg_q.retry   <= arp_pkg::RETRY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				arp_pkg::CFG_OWN_MAC:   cfg_q.own_mac <= cfg.data;
				arp_pkg::CFG_OWN_IP:    cfg_q.own_ip  <= cfg.data[31:0];
				arp_pkg::CFG_CACHE_TTL: cfg_q.ttl     <= cfg.data[31:0];
				arp_pkg::CFG_ARP_RETRY: cfg_q.retry   <= cfg.data[31:0];
				default: begin
				end
			endcase
		end
	end

	arp_fe u_fe (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg_q),
		.pop    (pop),
		.head   (head)
	);

	arp_be u_be (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

>>> verif/tb_arp_resolver_with_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP resolver testbench
// Directed and random sends, received frames and ticks. A local copy of the
// cache, the request table and the held queue predicts each result word,
// and a monitor compares the results in order. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_arp_resolver_with_cache;

	typedef struct packed {
		logic [2:0]  action;
		logic [47:0] dst_mac;
		logic [15:0] out_tag;
		logic [31:0] target_ip;
		logic [47:0] target_mac;
		logic        last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	arp_item_if   item();
	arp_result_if result();
	arp_cfg_if    cfg();

	arp_resolver_with_cache dut (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result), .cfg(cfg)
	);

	// model state
	logic [47:0] m_own_mac;
	logic [31:0] m_own_ip, m_ttl, m_retry, m_now;
	logic        c_vld [arp_pkg::CACHE_N];
	logic [31:0] c_ip [arp_pkg::CACHE_N];
	logic [47:0] c_mac [arp_pkg::CACHE_N];
	logic [31:0] c_stamp [arp_pkg::CACHE_N];
	logic        r_vld [arp_pkg::REQ_N];
	logic [31:0] r_ip [arp_pkg::REQ_N];
	logic [31:0] r_time [arp_pkg::REQ_N];
	logic        h_vld [arp_pkg::HELD_N];
	logic [31:0] h_ip [arp_pkg::HELD_N];
	logic [15:0] h_tag [arp_pkg::HELD_N];

	res_t expected_q [$];
	res_t pend [$];
	int   errors = 0;
	longint cycles = 0;
	bit   rx_hold = 1'b0;
	bit   rx_hold_req = 1'b0;
	logic [31:0] ip_pool [8];

	initial forever #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void push_res(input logic [2:0] a, input logic [47:0] d,
		input logic [15:0] t, input logic [31:0] ti, input logic [47:0] tm);
		res_t r;
		r = '{a, d, t, ti, tm, 1'b0};
		pend.push_back(r);
	endfunction

	function automatic void model_send(input logic [31:0] ip, input logic [15:0] tag);
		int hit, cnt, slot;
		logic [31:0] best, age;
		hit = -1; cnt = 0; slot = -1; best = '0;
		for (int i = 0; i < arp_pkg::CACHE_N; i++)
			if (c_vld[i] && c_ip[i] == ip) begin
				if (m_now - c_stamp[i] > m_ttl) c_vld[i] = 1'b0;
				else hit = i;
				break;
			end
		if (hit >= 0) begin
			push_res(arp_pkg::ACT_IPV4, c_mac[hit], tag, '0, '0);
			return;
		end
		for (int i = 0; i < arp_pkg::HELD_N; i++) if (h_vld[i]) cnt++;
		if (cnt < arp_pkg::HELD_N) begin
			h_vld[cnt] = 1'b1; h_ip[cnt] = ip; h_tag[cnt] = tag;
		end else push_res(arp_pkg::ACT_DROP, '0, tag, '0, '0);
		for (int i = 0; i < arp_pkg::REQ_N; i++)
			if (r_vld[i] && r_ip[i] == ip) begin
				if (m_now - r_time[i] > m_retry) begin
					r_time[i] = m_now;
					push_res(arp_pkg::ACT_REQ, arp_pkg::BCAST_MAC, '0, ip, '0);
				end
				return;
			end
		for (int i = 0; i < arp_pkg::REQ_N; i++) if (!r_vld[i]) begin slot = i; break; end
		if (slot < 0) begin
			slot = 0;
			for (int i = 0; i < arp_pkg::REQ_N; i++) begin
				age = m_now - r_time[i];
				if (age > best || i == 0) begin best = age; slot = i; end
			end
		end
		r_vld[slot] = 1'b1; r_ip[slot] = ip; r_time[slot] = m_now;
		push_res(arp_pkg::ACT_REQ, arp_pkg::BCAST_MAC, '0, ip, '0);
	endfunction

	function automatic void model_learn(input logic [31:0] ip, input logic [47:0] mac);
		int slot;
		logic [31:0] best, age;
		slot = -1; best = '0;
		for (int i = 0; i < arp_pkg::CACHE_N && slot < 0; i++)
			if (c_vld[i] && c_ip[i] == ip) slot = i;
		for (int i = 0; i < arp_pkg::CACHE_N && slot < 0; i++)
			if (!c_vld[i]) slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = 0; i < arp_pkg::CACHE_N; i++) begin
				age = m_now - c_stamp[i];
				if (age > best || i == 0) begin best = age; slot = i; end
			end
		end
		c_vld[slot] = 1'b1; c_ip[slot] = ip; c_mac[slot] = mac; c_stamp[slot] = m_now;
	endfunction

	function automatic void model_arp(input logic is_req, input logic [47:0] smac,
		input logic [31:0] sip, input logic [31:0] tip);
		int keep;
		bit pending;
		keep = 0; pending = 0;
		model_learn(sip, smac);
		for (int i = 0; i < arp_pkg::REQ_N; i++)
			if (r_vld[i] && r_ip[i] == sip) begin
				r_vld[i] = 1'b0; pending = 1; break;
			end
		if (pending) begin
			for (int i = 0; i < arp_pkg::HELD_N; i++) begin
				if (!h_vld[i]) continue;
				if (h_ip[i] == sip) push_res(arp_pkg::ACT_IPV4, smac, h_tag[i], '0, '0);
				else begin
					h_ip[keep] = h_ip[i]; h_tag[keep] = h_tag[i];
					h_vld[keep] = 1'b1; keep++;
				end
			end
			for (int i = keep; i < arp_pkg::HELD_N; i++) h_vld[i] = 1'b0;
		end
		if (is_req && tip == m_own_ip) push_res(arp_pkg::ACT_REPLY, smac, '0, sip, smac);
	endfunction

	// predicts the result words of one accepted item
	function automatic void predict_item();
		res_t r;
		pend.delete();
		case (item.kind)
			arp_pkg::KIND_SEND: model_send(item.hop_addr, item.payload_tag);
			arp_pkg::KIND_FRAME:
				if ((item.frame_dst_mac == m_own_mac ||
				     item.frame_dst_mac == arp_pkg::BCAST_MAC) && item.parse_ok) begin
					if (item.frame_type == arp_pkg::FTYPE_IPV4)
						push_res(arp_pkg::ACT_DELIV, '0, item.payload_tag, '0, '0);
					else if (item.frame_type == arp_pkg::FTYPE_ARP)
						model_arp(item.arp_is_request, item.arp_sender_mac,
							item.arp_sender_ip, item.arp_target_ip);
				end
			arp_pkg::KIND_TICK: m_now = m_now + {16'd0, item.tick_ms};
			default: ;
		endcase
		if (pend.size() > 0) begin
			r = pend.pop_back(); r.last = 1'b1; pend.push_back(r);
		end
		foreach (pend[i]) expected_q.push_back(pend[i]);
	endfunction

	// input acceptance feeds the predictor
	always @(posedge clk)
		if (arst_n && item.valid && item.ready) predict_item();

	// result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && result.valid && result.ready) begin
			got = '{result.action, result.dst_mac, result.out_tag, result.target_ip,
				result.target_mac, result.last};
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: mismatch expected no word, actual %h", $time, got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch expected act=%0d dst=%h tag=%h tip=%h tmac=%h last=%b",
						$time, want.action, want.dst_mac, want.out_tag, want.target_ip,
						want.target_mac, want.last);
					$display("%0t:            actual act=%0d dst=%h tag=%h tip=%h tmac=%h last=%b",
						$time, got.action, got.dst_mac, got.out_tag, got.target_ip,
						got.target_mac, got.last);
				end
			end
		end
	end

	// receiver ready with random stalls, or a long hold-off on request
	initial begin
		int w;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				result.ready <= 1'b0;
				rx_hold = 1'b1;
				repeat (300) @(negedge clk);
				rx_hold = 1'b0;
				rx_hold_req = 1'b0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 7));
			if (w > 0) begin
				result.ready <= 1'b0;
				repeat (w - 1) @(negedge clk);
				@(negedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	task automatic cfg_write(input logic [7:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			arp_pkg::CFG_OWN_MAC:   m_own_mac = val;
			arp_pkg::CFG_OWN_IP:    m_own_ip = val[31:0];
			arp_pkg::CFG_CACHE_TTL: m_ttl = val[31:0];
			arp_pkg::CFG_ARP_RETRY: m_retry = val[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// sends one word; random gap before it unless no_gap
	task automatic send_word(input logic [1:0] k, input logic [31:0] hop,
		input logic [15:0] tag, input logic [47:0] fdst, input logic [1:0] ft,
		input logic ok, input logic rq, input logic [47:0] smac,
		input logic [31:0] sip, input logic [31:0] tip, input logic [15:0] dt,
		input bit no_gap = 0);
		int w;
		w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 7));
		@(negedge clk);
		if (w > 0) begin
			item.valid <= 1'b0;
			repeat (w) @(negedge clk);
		end
		item.valid <= 1'b1; item.kind <= k; item.hop_addr <= hop;
		item.payload_tag <= tag; item.frame_dst_mac <= fdst; item.frame_type <= ft;
		item.parse_ok <= ok; item.arp_is_request <= rq; item.arp_sender_mac <= smac;
		item.arp_sender_ip <= sip; item.arp_target_ip <= tip; item.tick_ms <= dt;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
	endtask

	task automatic go_idle();
		@(negedge clk);
		item.valid <= 1'b0;
		while (expected_q.size() != 0 || rx_hold) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_ip(input logic [31:0] ip, input logic [15:0] tag);
		send_word(arp_pkg::KIND_SEND, ip, tag, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
	endtask

	task automatic arp_in(input logic [47:0] fdst, input logic rq, input logic [47:0] smac,
		input logic [31:0] sip, input logic [31:0] tip);
		send_word(arp_pkg::KIND_FRAME, $urandom, 16'($urandom), fdst, arp_pkg::FTYPE_ARP,
			1'b1, rq, smac, sip, tip, '0);
	endtask

	task automatic tick(input logic [15:0] dt);
		send_word(arp_pkg::KIND_TICK, $urandom, 16'($urandom), '0, '0, 1'b0, 1'b0, '0, '0,
			'0, dt);
	endtask

	// directed: miss, retry window, resolve, hit, expiry, reply, ignored frames
	task automatic test_directed();
		cfg_write(arp_pkg::CFG_OWN_MAC, 48'h0200_0000_0001);
		cfg_write(arp_pkg::CFG_OWN_IP, 48'h0A00_0001);
		cfg_write(arp_pkg::CFG_CACHE_TTL, 48'd1000);
		cfg_write(arp_pkg::CFG_ARP_RETRY, 48'd100);
		send_ip(32'h0A00_0002, 16'h0000);
		send_ip(32'h0A00_0002, 16'hFFFF);           // inside retry window
		tick(16'hFFFF);
		send_ip(32'h0A00_0002, 16'h1234);           // retry expired
		arp_in(arp_pkg::BCAST_MAC, 1'b1, 48'hFFFF_FFFF_FFFE, 32'h0A00_0002, 32'h0A00_0001);
		send_ip(32'h0A00_0002, 16'h5555);           // hit
		tick(16'd1000);
		send_ip(32'h0A00_0002, 16'h6666);           // age equals ttl: still hit
		tick(16'd1);
		send_ip(32'h0A00_0002, 16'h7777);           // expired
		send_word(arp_pkg::KIND_FRAME, '0, 16'hABCD, 48'h0200_0000_0001, arp_pkg::FTYPE_IPV4,
			1'b1, 1'b0, '0, '0, '0, '0);
		send_word(arp_pkg::KIND_FRAME, '0, 16'hABCE, 48'h0200_0000_0002, arp_pkg::FTYPE_IPV4,
			1'b1, 1'b0, '0, '0, '0, '0);
		send_word(arp_pkg::KIND_FRAME, '0, 16'hABCF, arp_pkg::BCAST_MAC, arp_pkg::FTYPE_IPV4,
			1'b0, 1'b0, '0, '0, '0, '0);
		send_word(arp_pkg::KIND_FRAME, '0, 16'h0001, arp_pkg::BCAST_MAC, arp_pkg::FTYPE_OTHER,
			1'b1, 1'b0, '0, '0, '0, '0);
		send_word(arp_pkg::KIND_FRAME, '0, 16'h0002, arp_pkg::BCAST_MAC, arp_pkg::FTYPE_RSVD,
			1'b1, 1'b0, '0, '0, '0, '0);
		send_word(arp_pkg::KIND_RSVD, 32'h0A00_0002, 16'h0003, '0, '0, 1'b1, 1'b0, '0, '0,
			'0, '0);
		arp_in(48'h0200_0000_0001, 1'b0, 48'h0, 32'hFFFF_FFFF, 32'h0);
		arp_in(arp_pkg::BCAST_MAC, 1'b1, 48'h1111, 32'h0A00_0009, 32'h0A00_0003); // not for us
		go_idle();
	endtask

	// held queue full, request table replacement, cache replacement
	task automatic test_tables();
		cfg_write(arp_pkg::CFG_ARP_RETRY, 48'hFFFF_FFFF);
		cfg_write(arp_pkg::CFG_CACHE_TTL, 48'hFFFF_FFFF);
		for (int i = 0; i < 18; i++) send_ip(32'hC0A8_0000 + 32'(i % 10), i[15:0]);
		for (int i = 0; i < 10; i++)
			arp_in(48'h0200_0000_0001, 1'b1, 48'hAA00 + 48'(i), 32'hC0A8_0000 + 32'(i),
				32'h0A00_0001);
		for (int i = 0; i < 20; i++) begin
			tick(16'($urandom_range(0, 50)));
			arp_in(arp_pkg::BCAST_MAC, 1'b0, 48'hBB00 + 48'(i), 32'hC0B0_0000 + 32'(i), '0);
		end
		for (int i = 0; i < 20; i++) send_ip(32'hC0B0_0000 + 32'(i), 16'h0100 + 16'(i));
		go_idle();
	endtask

	// random item with biased well-formed content
	task automatic rand_item();
		int sel;
		logic [31:0] ip, sip;
		logic [47:0] fdst;
		sel = int'($urandom_range(0, 99));
		ip = ip_pool[$urandom_range(0, 7)];
		sip = ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, 7)];
		case ($urandom_range(0, 3))
			0: fdst = m_own_mac;
			1: fdst = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom}) : m_own_mac;
			default: fdst = arp_pkg::BCAST_MAC;
		endcase
		if (sel < 40)
			send_ip(($urandom_range(0, 15) == 0) ? $urandom : ip, 16'($urandom));
		else if (sel < 70)
			arp_in(fdst, 1'($urandom_range(0, 1)), 48'({$urandom, $urandom}), sip,
				($urandom_range(0, 1) != 0) ? m_own_ip : $urandom);
		else if (sel < 80)
			send_word(arp_pkg::KIND_FRAME, $urandom, 16'($urandom), fdst,
				2'($urandom_range(0, 3)), $urandom_range(0, 5) != 0, 1'($urandom),
				48'({$urandom, $urandom}), $urandom, $urandom, 16'($urandom));
		else if (sel < 95)
			tick(16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400)));
		else
			send_word(arp_pkg::KIND_RSVD, $urandom, 16'($urandom), 48'({$urandom, $urandom}),
				2'($urandom), 1'($urandom), 1'($urandom), 48'({$urandom, $urandom}),
				$urandom, $urandom, 16'($urandom));
	endtask

	task automatic test_random(input int n, input logic [31:0] ttl, input logic [31:0] rty);
		cfg_write(arp_pkg::CFG_OWN_MAC, 48'({$urandom, $urandom}));
		cfg_write(arp_pkg::CFG_OWN_IP, {16'd0, $urandom});
		cfg_write(arp_pkg::CFG_CACHE_TTL, {16'd0, ttl});
		cfg_write(arp_pkg::CFG_ARP_RETRY, {16'd0, rty});
		for (int i = 0; i < 8; i++) ip_pool[i] = $urandom;
		for (int i = 0; i < n; i++) rand_item();
		go_idle();
	endtask

	// receiver holds off while IPv4 frames keep coming, then sender waits for drain
	task automatic test_backpressure();
		rx_hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word(arp_pkg::KIND_FRAME, '0, i[15:0], arp_pkg::BCAST_MAC,
				arp_pkg::FTYPE_IPV4, 1'b1, 1'b0, '0, '0, '0, '0, 1);
		go_idle();
		for (int i = 0; i < 30; i++) rand_item();
		go_idle();
	endtask

	initial begin
		item.valid = 1'b0; item.kind = '0; item.hop_addr = '0; item.payload_tag = '0;
		item.frame_dst_mac = '0; item.frame_type = '0; item.parse_ok = 1'b0;
		item.arp_is_request = 1'b0; item.arp_sender_mac = '0; item.arp_sender_ip = '0;
		item.arp_target_ip = '0; item.tick_ms = '0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		m_own_mac = '0; m_own_ip = '0; m_ttl = arp_pkg::TTL_RST; m_retry = arp_pkg::RETRY_RST;
		m_now = '0;
		for (int i = 0; i < arp_pkg::CACHE_N; i++) c_vld[i] = 1'b0;
		for (int i = 0; i < arp_pkg::REQ_N; i++) r_vld[i] = 1'b0;
		for (int i = 0; i < arp_pkg::HELD_N; i++) h_vld[i] = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (30) @(posedge clk);
		test_directed();
		test_tables();
		test_random(100, 32'd500, 32'd200);
		test_backpressure();
		test_random(100, 32'd0, 32'd0);
		test_random(100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
